>>> sv/rsnh_pkg.sv
// Shared constants, codes and types for the ray segment nearest hit core.
`default_nettype none
package rsnh_pkg;

    localparam int SEGMENTS_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int SLOT_W         = 6;
    localparam int CFG_W          = 7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_FIN
    } state_t;

    // status of the nearest-hit select unit
    typedef struct packed {
        logic busy;
        logic found;
    } sel_status_t;

endpackage
`default_nettype wire

>>> sv/rsnh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsnh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> sv/rsnh_scan.sv
// Three-stage segment test pipeline: differences, cross products, bounds.
`default_nettype none
module rsnh_scan
    import rsnh_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire logic [4*W-1:0]      entry,
    input  wire logic signed [W-1:0] ax,
    input  wire logic signed [W-1:0] ay,
    input  wire logic signed [W-1:0] bx,
    input  wire logic signed [W-1:0] by,
    input  wire logic signed [W:0]   rx,
    input  wire logic signed [W:0]   ry,
    output logic                     cand_valid,
    output logic                     cand_hit,
    output logic [2*W+1:0]           cand_tn,
    output logic [2*W+1:0]           cand_den,
    output logic                     busy
);
    localparam int PW  = 2*W+2;   // product width
    localparam int DSW = 2*W+3;   // cross product difference width
    localparam int MW  = 2*W+2;   // magnitude width

    logic signed [W-1:0] cx, cy, dx, dy;
    logic                skip_c;

    logic                v1_reg, v2_reg, v3_reg;
    logic                skip1_reg, skip2_reg, hit3_reg;
    logic signed [W:0]   sx_reg, sy_reg, qx_reg, qy_reg;
    logic signed [PW-1:0] rsy_reg, rysx_reg, qxsy_reg, qysx_reg, qxry_reg, qyrx_reg;
    logic [MW-1:0]       tn3_reg, den3_reg;

    logic signed [DSW-1:0] den_s, tn_s, un_s, den_n, tn_n, un_n;
    logic                  hit_c;

    assign cx = entry[W-1:0];
    assign cy = entry[2*W-1:W];
    assign dx = entry[3*W-1:2*W];
    assign dy = entry[4*W-1:3*W];

    // the ray's own segment, either direction
    assign skip_c = (cx == bx && cy == by && dx == ax && dy == ay) ||
                    (dx == bx && dy == by && cx == ax && cy == ay);

    always_comb begin
        den_s = DSW'(rsy_reg)  - DSW'(rysx_reg);
        tn_s  = DSW'(qxsy_reg) - DSW'(qysx_reg);
        un_s  = DSW'(qxry_reg) - DSW'(qyrx_reg);
        if (den_s[DSW-1]) begin
            den_n = -den_s;
            tn_n  = -tn_s;
            un_n  = -un_s;
        end else begin
            den_n = den_s;
            tn_n  = tn_s;
            un_n  = un_s;
        end
        hit_c = !skip2_reg && (den_s != '0) &&
                !tn_n[DSW-1] && (tn_n <= den_n) &&
                !un_n[DSW-1] && (un_n <= den_n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            skip1_reg <= skip_c;
            sx_reg    <= (W+1)'(dx) - (W+1)'(cx);
            sy_reg    <= (W+1)'(dy) - (W+1)'(cy);
            qx_reg    <= (W+1)'(cx) - (W+1)'(ax);
            qy_reg    <= (W+1)'(cy) - (W+1)'(ay);
            skip2_reg <= skip1_reg;
            rsy_reg   <= rx * sy_reg;
            rysx_reg  <= ry * sx_reg;
            qxsy_reg  <= qx_reg * sy_reg;
            qysx_reg  <= qy_reg * sx_reg;
            qxry_reg  <= qx_reg * ry;
            qyrx_reg  <= qy_reg * rx;
            hit3_reg  <= hit_c;
            tn3_reg   <= tn_n[MW-1:0];
            den3_reg  <= den_n[MW-1:0];
        end
    end

    assign cand_valid = v3_reg;
    assign cand_hit   = hit3_reg;
    assign cand_tn    = tn3_reg;
    assign cand_den   = den3_reg;
    assign busy       = v1_reg | v2_reg | v3_reg;
endmodule
`default_nettype wire

>>> sv/rsnh_select.sv
// Nearest-hit select: exact t compare by split cross multiplication.
`default_nettype none
module rsnh_select
    import rsnh_pkg::*;
#(
    parameter int MW = 2*COORD_BITS_DEF+2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clear,
    input  wire logic          take,
    input  wire logic [MW-1:0] tn_in,
    input  wire logic [MW-1:0] den_in,
    output sel_status_t        status,
    output logic [MW-1:0]      best_tn,
    output logic [MW-1:0]      best_den
);
    localparam int H  = (MW+1)/2;
    localparam int HW = MW-H;
    localparam int PW = 2*MW;

    logic            c1_reg, c2_reg, found_reg;
    logic [MW-1:0]   tn1_reg, den1_reg, tn2_reg, den2_reg;
    logic [MW-1:0]   best_tn_reg, best_den_reg;
    logic [2*H-1:0]  all_reg, bll_reg;
    logic [MW-1:0]   alh_reg, ahl_reg, blh_reg, bhl_reg;
    logic [2*HW-1:0] ahh_reg, bhh_reg;
    logic [PW-1:0]   a_reg, b_reg;
    logic            less;

    assign less = a_reg < b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg    <= 1'b0;
            c2_reg    <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            c1_reg <= take;
            c2_reg <= c1_reg;
            if (clear) begin
                found_reg <= 1'b0;
            end else if (c2_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        // a = tn_new * best_den, b = best_tn * den_new
        tn1_reg  <= tn_in;
        den1_reg <= den_in;
        all_reg  <= tn_in[H-1:0]  * best_den_reg[H-1:0];
        alh_reg  <= tn_in[H-1:0]  * best_den_reg[MW-1:H];
        ahl_reg  <= tn_in[MW-1:H] * best_den_reg[H-1:0];
        ahh_reg  <= tn_in[MW-1:H] * best_den_reg[MW-1:H];
        bll_reg  <= best_tn_reg[H-1:0]  * den_in[H-1:0];
        blh_reg  <= best_tn_reg[H-1:0]  * den_in[MW-1:H];
        bhl_reg  <= best_tn_reg[MW-1:H] * den_in[H-1:0];
        bhh_reg  <= best_tn_reg[MW-1:H] * den_in[MW-1:H];
        tn2_reg  <= tn1_reg;
        den2_reg <= den1_reg;
        a_reg    <= PW'(all_reg) + (PW'(alh_reg) << H) + (PW'(ahl_reg) << H)
                    + (PW'(ahh_reg) << (2*H));
        b_reg    <= PW'(bll_reg) + (PW'(blh_reg) << H) + (PW'(bhl_reg) << H)
                    + (PW'(bhh_reg) << (2*H));
        // strict less keeps the earlier entry on a tie
        if (c2_reg && (!found_reg || less)) begin
            best_tn_reg  <= tn2_reg;
            best_den_reg <= den2_reg;
        end
    end

    assign status.busy  = c1_reg | c2_reg;
    assign status.found = found_reg;
    assign best_tn      = best_tn_reg;
    assign best_den     = best_den_reg;
endmodule
`default_nettype wire

>>> sv/rsnh_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rsnh_div #(
    parameter int NW = 52,
    parameter int DW = 34,
    parameter int QW = 17
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [QW-1:0]      quot
);
    localparam int CW = $clog2(QW+1);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic [QW-1:0] q_reg;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, q_reg[QW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // top part of the numerator is below den since the quotient fits QW bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[NW-1:QW];
            q_reg   <= num[QW-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

>>> sv/ray_segment_nearest_hit_core.sv
// Top level: segment table, scan sequencer and nearest hit point unit.
// Usage:
//   s_ words carry a load (s_tuser = 0) or a cast (s_tuser = 1). A load
//   writes one segment into the table and gives no result. A cast tests the
//   first segments_in_use entries and gives one m_ word: the nearest hit
//   point (m_tuser = 1) or the destination (m_tuser = 0).
//   cfg_ writes segments_in_use; write it only while the core is idle.
// Flow:
//   A cast reads one table entry per cycle, while no hit waits for the
//   select unit, from the RAM into a three-stage test pipeline. Each
//   hitting segment gets an exact t compare in the select unit, and the
//   hit point is divided out when something was hit.
//   One cast is worked at a time; s_tready is low from cast accept until
//   its result goes into the output register.
// Reset: control clears; the table is undefined until loaded.
// Stall: the result waits in the output register while m_tready is low;
//   a new word is taken meanwhile, and a following cast holds its result
//   until the output register is free.
`default_nettype none
module ray_segment_nearest_hit_core
    import rsnh_pkg::*;
#(
    parameter int SEGMENTS   = SEGMENTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // slot, start_x, start_y, end_x, end_y, zero pad
    input  wire logic [((SLOT_W + 4*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // operation
    input  wire logic [0:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // hit_x, hit_y, zero pad
    output logic [((2*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // found
    output logic [0:0]                 m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data
);
    localparam int W         = COORD_BITS;
    localparam int S_TDATA_W = ((SLOT_W + 4*W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2*W + 7) / 8) * 8;
    localparam int AW        = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CW        = $clog2(SEGMENTS + 1);
    localparam int MW        = 2*W + 2;
    localparam int H         = W + 1;
    localparam int NW        = MW + H;
    localparam logic signed [W+2:0] CMAX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] CMIN = {4'b1111, {(W-1){1'b0}}};

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    cfg_reg;
    logic [CW-1:0]       idx_reg, count_reg, count_c;
    logic signed [W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [W:0]   rx_reg, ry_reg;
    logic [H-1:0]        mx, my;

    logic [SLOT_W-1:0]   in_slot;
    logic [4*W-1:0]      in_seg;
    logic                s_acc, cast_acc, ram_we;

    logic                v0_reg, adv, issue, take, div_start, out_load, s_ready_c;
    logic [4*W-1:0]      entry;
    logic                cand_valid, cand_hit, scan_busy;
    logic [MW-1:0]       cand_tn, cand_den, best_tn, best_den;
    sel_status_t         sel_st;

    logic [2*H-1:0]      pxl_reg, pyl_reg;
    logic [NW-H-1:0]     pxh_reg, pyh_reg;
    logic [NW-1:0]       num_x, num_y;
    logic                dx_done, dy_done;
    logic [H-1:0]        qx, qy;
    logic signed [W+2:0] sum_x, sum_y;
    logic signed [W-1:0] hit_x, hit_y;

    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                m_found_reg;

    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_seg   = s_tdata[SLOT_W+4*W-1:SLOT_W];
    assign s_acc    = s_tvalid && s_ready_c;
    assign cast_acc = s_acc && (s_tuser[0] == OP_CAST);
    assign ram_we   = s_acc && (s_tuser[0] == OP_LOAD) && (32'(in_slot) < SEGMENTS);
    assign count_c  = (32'(cfg_reg) > SEGMENTS) ? CW'(SEGMENTS) : CW'(cfg_reg);

    // scan stalls only while a hit waits for the select unit
    assign adv  = !(cand_valid && cand_hit && sel_st.busy);
    assign take = cand_valid && cand_hit && !sel_st.busy;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (cast_acc) state_next = ST_SCAN;
            ST_SCAN:  if (idx_reg == count_reg) state_next = ST_DRAIN;
            ST_DRAIN: begin
                if (!v0_reg && !scan_busy && !sel_st.busy) begin
                    state_next = sel_st.found ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DIV;
            // both dividers run in lockstep
            ST_DIV:   if (dx_done && dy_done) state_next = ST_FIN;
            ST_FIN:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready_c = 1'b0;
        issue     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready_c = 1'b1;
            ST_SCAN: issue     = adv && (idx_reg != count_reg);
            ST_SUM:  div_start = 1'b1;
            ST_FIN:  out_load  = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= '0;
            v0_reg      <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            if (adv) begin
                v0_reg <= issue;
            end
            if (cast_acc) begin
                idx_reg <= '0;
            end else if (issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign mx = rx_reg[W] ? H'(-rx_reg) : H'(rx_reg);
    assign my = ry_reg[W] ? H'(-ry_reg) : H'(ry_reg);

    always_ff @(posedge aclk) begin
        if (cast_acc) begin
            ax_reg    <= in_seg[W-1:0];
            ay_reg    <= in_seg[2*W-1:W];
            bx_reg    <= in_seg[3*W-1:2*W];
            by_reg    <= in_seg[4*W-1:3*W];
            rx_reg    <= (W+1)'($signed(in_seg[3*W-1:2*W]))
                         - (W+1)'($signed(in_seg[W-1:0]));
            ry_reg    <= (W+1)'($signed(in_seg[4*W-1:3*W]))
                         - (W+1)'($signed(in_seg[2*W-1:W]));
            count_reg <= count_c;
        end
        // hit point numerator |tn * r|, split over tn halves
        pxl_reg <= best_tn[H-1:0] * mx;
        pxh_reg <= best_tn[MW-1:H] * mx;
        pyl_reg <= best_tn[H-1:0] * my;
        pyh_reg <= best_tn[MW-1:H] * my;
        if (out_load) begin
            m_found_reg <= sel_st.found;
            m_data_reg  <= M_TDATA_W'({sel_st.found ? hit_y : by_reg,
                                       sel_st.found ? hit_x : bx_reg});
        end
    end

    assign num_x = NW'(pxl_reg) + (NW'(pxh_reg) << H);
    assign num_y = NW'(pyl_reg) + (NW'(pyh_reg) << H);

    // origin + truncated quotient, saturated
    always_comb begin
        sum_x = (W+3)'(ax_reg) + (rx_reg[W] ? -(W+3)'({1'b0, qx}) : (W+3)'({1'b0, qx}));
        sum_y = (W+3)'(ay_reg) + (ry_reg[W] ? -(W+3)'({1'b0, qy}) : (W+3)'({1'b0, qy}));
        if (sum_x > CMAX)      hit_x = CMAX[W-1:0];
        else if (sum_x < CMIN) hit_x = CMIN[W-1:0];
        else                   hit_x = sum_x[W-1:0];
        if (sum_y > CMAX)      hit_y = CMAX[W-1:0];
        else if (sum_y < CMIN) hit_y = CMIN[W-1:0];
        else                   hit_y = sum_y[W-1:0];
    end

    rsnh_ram #(.WIDTH(4*W), .DEPTH(SEGMENTS)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(in_slot)),
        .wdata (in_seg),
        .re    (adv),
        .raddr (idx_reg[AW-1:0]),
        .rdata (entry)
    );

    rsnh_scan #(.W(W)) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (v0_reg),
        .entry      (entry),
        .ax         (ax_reg),
        .ay         (ay_reg),
        .bx         (bx_reg),
        .by         (by_reg),
        .rx         (rx_reg),
        .ry         (ry_reg),
        .cand_valid (cand_valid),
        .cand_hit   (cand_hit),
        .cand_tn    (cand_tn),
        .cand_den   (cand_den),
        .busy       (scan_busy)
    );

    rsnh_select #(.MW(MW)) u_select (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cast_acc),
        .take     (take),
        .tn_in    (cand_tn),
        .den_in   (cand_den),
        .status   (sel_st),
        .best_tn  (best_tn),
        .best_den (best_den)
    );

    rsnh_div #(.NW(NW), .DW(MW), .QW(H)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_x),
        .den     (best_den),
        .done    (dx_done),
        .quot    (qx)
    );

    rsnh_div #(.NW(NW), .DW(MW), .QW(H)) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_y),
        .den     (best_den),
        .done    (dy_done),
        .quot    (qy)
    );

    assign s_tready   = s_ready_c;
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_found_reg;
endmodule
`default_nettype wire

>>> sv/rsnh_checker.sv
// Port-level checker for the ray segment nearest hit core, with its bind.
`default_nettype none
module rsnh_checker
    import rsnh_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [0:0]            s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [((2*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input wire logic [0:0]            m_tuser
);
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_cast_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("input taken during a cast");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("result after a load");
endmodule

bind ray_segment_nearest_hit_core rsnh_checker #(.COORD_BITS(COORD_BITS)) u_rsnh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the ray segment nearest hit core.
`timescale 1ns / 100ps

// Predicts the nearest-hit answer of every cast and checks the core's words.
class hit_scoreboard;
    typedef struct {
        bit      found;
        shortint hx;
        shortint hy;
    } hit_t;

    shortint seg_tbl [64][4];
    int unsigned seg_count;
    hit_t    pending_hits[$];
    int      errors;

    function new();
        seg_count = 0;
        errors    = 0;
    endfunction

    function void set_count(bit [6:0] v);
        seg_count = (v > 64) ? 64 : v;
    endfunction

    function longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // accepted s_ word: update the table or predict the cast's answer
    function void note_word(bit op, bit [5:0] slot, shortint ax_i, shortint ay_i,
                            shortint bx_i, shortint by_i);
        longint ax, ay, bx, by, rx, ry, cx, cy, dx, dy, sx, sy, qx, qy;
        longint den, tn, un, best_tn, best_den;
        bit [127:0] lhs, rhs;
        hit_t h;
        ax = ax_i; ay = ay_i; bx = bx_i; by = by_i;
        if (op == rsnh_pkg::OP_LOAD) begin
            seg_tbl[slot] = '{ax_i, ay_i, bx_i, by_i};
            return;
        end
        rx = bx - ax;
        ry = by - ay;
        h.found = 0;
        h.hx = bx_i;
        h.hy = by_i;
        best_tn = 0;
        best_den = 1;
        for (int i = 0; i < seg_count; i++) begin
            cx = seg_tbl[i][0]; cy = seg_tbl[i][1];
            dx = seg_tbl[i][2]; dy = seg_tbl[i][3];
            // the ray's own segment, either direction
            if ((cx == bx && cy == by && dx == ax && dy == ay) ||
                (dx == bx && dy == by && cx == ax && cy == ay))
                continue;
            sx = dx - cx;
            sy = dy - cy;
            den = rx * sy - ry * sx;
            if (den == 0) continue;
            qx = cx - ax;
            qy = cy - ay;
            tn = qx * sy - qy * sx;
            un = qx * ry - qy * rx;
            if (den < 0) begin
                den = -den; tn = -tn; un = -un;
            end
            if (tn < 0 || tn > den || un < 0 || un > den) continue;
            lhs = 128'(tn);
            lhs = lhs * 128'(best_den);
            rhs = 128'(best_tn);
            rhs = rhs * 128'(den);
            // strict compare keeps the lower entry on a tie
            if (!h.found || lhs < rhs) begin
                h.found  = 1;
                best_tn  = tn;
                best_den = den;
                h.hx = shortint'(clamp16(ax + (tn * rx) / den));
                h.hy = shortint'(clamp16(ay + (tn * ry) / den));
            end
        end
        pending_hits = {pending_hits, h};
    endfunction

    function void check_hit(bit found, shortint hx, shortint hy);
        hit_t e;
        if (pending_hits.size() == 0) begin
            $error("result word with no cast pending");
            errors++;
            return;
        end
        e = pending_hits.pop_front();
        if (found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, found);
            errors++;
        end
        if (hx !== e.hx) begin
            $error("hit_x: expected %0d, got %0d", e.hx, hx);
            errors++;
        end
        if (hy !== e.hy) begin
            $error("hit_y: expected %0d, got %0d", e.hy, hy);
            errors++;
        end
    endfunction
endclass

module testbench;
    import rsnh_pkg::*;

    localparam int LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // slot, start_x, start_y, end_x, end_y, pad
    logic [0:0]  s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // hit_x, hit_y
    logic [0:0]  m_tuser;   // found
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    hit_scoreboard board;
    bit  gaps_on;
    bit  hold_req;
    int  burst_left;
    longint cycles;

    ray_segment_nearest_hit_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: stall pattern changes mode every so often; a hold request
    // keeps m_tready low for a long stretch so the core backs up
    initial begin
        int mode, left, hold;
        m_tready = 0;
        mode = 0; left = 0; hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                hold = 400;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 120);
            end
            left--;
            if (hold > 0) begin
                hold--;
                m_tready <= 0;
            end else begin
                case (mode)
                    0: m_tready <= 1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_hit(m_tuser[0], m_tdata[15:0], m_tdata[31:16]);
    end

    // one s_ word; s_tvalid stays high after acceptance until the next call
    // or an idle gap lowers it
    task automatic send_word(bit op, bit [5:0] slot, shortint ax, shortint ay,
                             shortint bx, shortint by);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge aclk);
            s_tvalid <= 0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, by, bx, ay, ax, slot};
        do @(posedge aclk); while (!s_tready);
        board.note_word(op, slot, ax, ay, bx, by);
    endtask

    task automatic idle_sender();
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    // waits for all answers plus the core's tail, then writes segments_in_use
    task automatic write_count(bit [6:0] v);
        idle_sender();
        while (board.pending_hits.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        board.set_count(v);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic shortint rand_coord();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return shortint'($urandom_range(0, 512)) - 256;
        if (k < 85) return shortint'($urandom);
        case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    initial begin
        bit [6:0] counts[8] = '{7'd127, 7'd64, 7'd1, 7'd17, 7'd0, 7'd64, 7'd40, 7'd100};
        int j;
        board = new();
        aresetn = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = OP_LOAD;
        cfg_valid = 0; cfg_data = '0;
        hold_req = 0;
        gaps_on = 0;
        burst_left = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: empty table, then a small hand-built scene
        write_count(7'd0);
        send_word(OP_CAST, 6'd0, 16, 32, 48, 64);
        send_word(OP_LOAD, 6'd0, 100, -100, 100, 100);     // vertical at x=100
        send_word(OP_LOAD, 6'd1, 200, -100, 200, 100);
        send_word(OP_LOAD, 6'd2, 50, -50, 150, 50);        // crosses y=0 at x=100: tie
        send_word(OP_LOAD, 6'd3, 0, 0, 400, 0);            // collinear with the casts along y=0
        send_word(OP_LOAD, 6'd4, -32768, -32768, 32767, 32767);
        send_word(OP_LOAD, 6'd5, 300, 0, 300, 80);         // touches ray at an end
        send_word(OP_LOAD, 6'd6, 20, 20, 20, 20);          // zero-length segment
        send_word(OP_LOAD, 6'd7, 0, -32768, 0, 32767);
        write_count(7'd8);
        send_word(OP_CAST, 6'd63, 0, 0, 400, 0);           // own segment skipped
        send_word(OP_CAST, 6'd0, 400, 0, 0, 0);            // own segment reversed
        send_word(OP_CAST, 6'd0, 10, 0, 400, 0);
        send_word(OP_CAST, 6'd0, 5, 5, 5, 5);              // zero-length ray
        send_word(OP_CAST, 6'd0, -32768, -32768, 32767, 32767);
        send_word(OP_CAST, 6'd0, 32767, -32768, -32768, 32767);
        send_word(OP_CAST, 6'd0, 300, 120, 300, -40);
        send_word(OP_CAST, 6'd0, -500, 10, 500, 10);

        // fill the whole table before any count can reach it
        for (int s = 8; s < 64; s++)
            send_word(OP_LOAD, 6'(s), rand_coord(), rand_coord(), rand_coord(), rand_coord());

        foreach (counts[p]) begin
            write_count(counts[p]);
            gaps_on = (p % 3) != 1;
            if (p == 2) hold_req = 1;
            for (int n = 0; n < 205; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_word(OP_LOAD, 6'($urandom_range(0, 63)), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord());
                end else if ($urandom_range(0, 6) == 0) begin
                    j = $urandom_range(0, 63);
                    if ($urandom_range(0, 1))
                        send_word(OP_CAST, 6'($urandom), board.seg_tbl[j][0],
                                  board.seg_tbl[j][1], board.seg_tbl[j][2],
                                  board.seg_tbl[j][3]);
                    else
                        send_word(OP_CAST, 6'($urandom), board.seg_tbl[j][2],
                                  board.seg_tbl[j][3], board.seg_tbl[j][0],
                                  board.seg_tbl[j][1]);
                end else begin
                    send_word(OP_CAST, 6'($urandom), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord());
                end
            end
        end

        idle_sender();
        while (board.pending_hits.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> files.f
sv/rsnh_pkg.sv
sv/rsnh_ram.sv
sv/rsnh_scan.sv
sv/rsnh_select.sv
sv/rsnh_div.sv
sv/ray_segment_nearest_hit_core.sv
sv/rsnh_checker.sv
tb/testbench.sv
